>>> sv/kcr_pkg.sv
// shared constants, types and helpers for the keyframe color ramp
package kcr_pkg;

   localparam int KEYS_MAX   = 5;
   localparam int KEY_W      = 41;
   localparam int ANGLE_W    = 17;
   localparam int RATE_W     = 16;
   localparam int ELAPSED_W  = 16;
   localparam int CHAN_W     = 8;
   localparam int IDX_W      = 3;
   localparam int COUNT_W    = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int FRAC_W     = 17;
   localparam int TIME_LSB   = 24;

   localparam logic [ANGLE_W-1:0] PERIOD  = 17'd92160;
   localparam logic [FRAC_W-1:0]  ONE_Q16 = 17'd65536;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ADVANCE_RATE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_COUNT    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_ZERO     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_FOUR     = 3'd6;

   localparam logic [RATE_W-1:0]  RATE_RESET  = 16'd1408;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 3'd5;
   localparam logic [KEY_W-1:0]   KEY_RESET [KEYS_MAX] = '{
      41'd128852958750,
      41'd386563609683,
      41'd773108840845,
      41'd1159653678272,
      41'd1417341181470
   };

   // time field of a key, folded into one period
   function automatic logic [ANGLE_W-1:0] key_time(input logic [KEY_W-1:0] key);
      logic [ANGLE_W-1:0] t;
      t = key[KEY_W-1:TIME_LSB];
      return (t >= PERIOD) ? t - PERIOD : t;
   endfunction

   localparam logic [ANGLE_W-1:0] KEY0_TIME = key_time(KEY_RESET[0]);
   localparam logic [ANGLE_W-1:0] POS_RESET =
      (KEY0_TIME == '0) ? PERIOD - 17'd1 : KEY0_TIME - 17'd1;

   typedef struct packed {
      logic       load_in;
      logic       mul;
      logic       pos;
      logic       offset;
      logic       setup;
      logic       div_step;
      logic       mix_step;
      logic [1:0] mix_chan;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic div_needed;
      logic slot_free;
   } status_type;

endpackage

>>> sv/kcr_csr.sv
// configuration register file: advance rate, key count and keyframes
module kcr_csr #(
   parameter int MAX_KEYS = kcr_pkg::KEYS_MAX
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   input  logic [kcr_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [kcr_pkg::KEY_W-1:0]           csr_data,
   output logic                                csr_ready,
   output logic [kcr_pkg::RATE_W-1:0]          advance_rate,
   output logic [kcr_pkg::COUNT_W-1:0]         key_count,
   output logic [kcr_pkg::KEY_W-1:0]           keys [MAX_KEYS]
);
   import kcr_pkg::*;

   logic [RATE_W-1:0]  rate_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [KEY_W-1:0]   keys_ff [MAX_KEYS];
   logic [CSR_IDX_W-1:0] key_sel;

   assign csr_ready = 1'b1;
   assign key_sel   = csr_index - CSR_KEY_ZERO;

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff  <= RATE_RESET;
         count_ff <= COUNT_RESET;
         for (int i = 0; i < MAX_KEYS; i++) begin
            keys_ff[i] <= KEY_RESET[i];
         end
      end else if (csr_valid) begin
         if (csr_index == CSR_ADVANCE_RATE) begin
            rate_ff <= csr_data[RATE_W-1:0];
         end
         if (csr_index == CSR_KEY_COUNT) begin
            count_ff <= csr_data[COUNT_W-1:0];
         end
         // keys past the parameter limit are never read, so they are not kept
         for (int i = 0; i < MAX_KEYS; i++) begin
            if (csr_index >= CSR_KEY_ZERO && csr_index <= CSR_KEY_FOUR &&
                key_sel == CSR_IDX_W'(i)) begin
               keys_ff[i] <= csr_data;
            end
         end
      end
   end

   assign advance_rate = rate_ff;
   assign key_count    = count_ff;
   always_comb begin
      for (int i = 0; i < MAX_KEYS; i++) begin
         keys[i] = keys_ff[i];
      end
   end

endmodule

>>> sv/kcr_ctrl.sv
// sequencing state machine for one item
module kcr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  kcr_pkg::status_type   status,
   output kcr_pkg::cmd_type      cmd
);
   import kcr_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_MUL   = 3'd1;
   localparam logic [2:0] S_POS   = 3'd2;
   localparam logic [2:0] S_DIST  = 3'd3;
   localparam logic [2:0] S_SETUP = 3'd4;
   localparam logic [2:0] S_DIV   = 3'd5;
   localparam logic [2:0] S_MIX   = 3'd6;
   localparam logic [2:0] S_OUT   = 3'd7;

   localparam logic [4:0] DIV_LAST = 5'(FRAC_W - 1);
   localparam logic [4:0] MIX_LAST = 5'd2;

   logic [2:0] state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      cmd.mix_chan = cnt_ff[1:0];
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_POS;
         end
         S_POS: begin
            cmd.pos  = 1'b1;
            state_in = S_DIST;
         end
         S_DIST: begin
            cmd.offset = 1'b1;
            state_in   = S_SETUP;
         end
         S_SETUP: begin
            cmd.setup = 1'b1;
            cnt_in    = '0;
            state_in  = status.div_needed ? S_DIV : S_MIX;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == DIV_LAST) begin
               cnt_in   = '0;
               state_in = S_MIX;
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
         end
         S_MIX: begin
            cmd.mix_step = 1'b1;
            cnt_in       = cnt_ff + 5'd1;
            if (cnt_ff == MIX_LAST) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (status.slot_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

endmodule

>>> sv/kcr_dp.sv
// datapath: position, segment fraction divider, color lerp, output register
module kcr_dp #(
   parameter int MAX_KEYS = kcr_pkg::KEYS_MAX
) (
   input  logic                              clock,
   input  logic                              reset,
   input  kcr_pkg::cmd_type                  cmd,
   output kcr_pkg::status_type               status,
   input  logic [kcr_pkg::ELAPSED_W-1:0]     req_elapsed_time,
   input  logic [kcr_pkg::RATE_W-1:0]        advance_rate,
   input  logic [kcr_pkg::COUNT_W-1:0]       key_count,
   input  logic [kcr_pkg::KEY_W-1:0]         keys [MAX_KEYS],
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [kcr_pkg::CHAN_W-1:0]        rsp_red_out,
   output logic [kcr_pkg::CHAN_W-1:0]        rsp_green_out,
   output logic [kcr_pkg::CHAN_W-1:0]        rsp_blue_out,
   output logic [kcr_pkg::IDX_W-1:0]         rsp_segment_from
);
   import kcr_pkg::*;

   localparam int KI_W = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
   localparam logic [IDX_W-1:0] KEYS_LIM = IDX_W'(MAX_KEYS);
   localparam logic [IDX_W-1:0] MIN_KEYS = 3'd2;

   logic [ELAPSED_W-1:0] elapsed_ff;
   logic [RATE_W-1:0]    delta_ff;
   logic [ANGLE_W-1:0]   pos_ff, pos_in;
   logic [IDX_W-1:0]     from_ff, to_ff, cur_from_ff, cur_to_ff;
   logic [ANGLE_W-1:0]   ft_ff, span_ff, d_ff;
   logic [ANGLE_W:0]     rem_ff;
   logic [FRAC_W-1:0]    quo_ff;
   logic                 step_ff;
   logic [CHAN_W-1:0]    col_ff [3];
   logic                 rsp_valid_ff;
   logic [CHAN_W-1:0]    red_ff, green_ff, blue_ff;
   logic [IDX_W-1:0]     seg_ff;

   // advance
   logic [ELAPSED_W+RATE_W-1:0] adv_prod;
   logic [ANGLE_W:0]            pos_sum;
   assign adv_prod = elapsed_ff * advance_rate;
   assign pos_sum  = {1'b0, pos_ff} + (ANGLE_W+1)'(delta_ff);
   assign pos_in   = (pos_sum >= {1'b0, PERIOD}) ? ANGLE_W'(pos_sum - {1'b0, PERIOD})
                                                 : pos_sum[ANGLE_W-1:0];

   // segment keys, out-of-range indices fall back to key zero
   logic [IDX_W-1:0]   safe_from, safe_to;
   logic [ANGLE_W-1:0] ft_c, tt_c, span_c;
   assign safe_from = (from_ff < KEYS_LIM) ? from_ff : '0;
   assign safe_to   = (to_ff < KEYS_LIM) ? to_ff : '0;
   assign ft_c   = key_time(keys[safe_from[KI_W-1:0]]);
   assign tt_c   = key_time(keys[safe_to[KI_W-1:0]]);
   assign span_c = (tt_c >= ft_c) ? tt_c - ft_c : tt_c + PERIOD - ft_c;

   logic [ANGLE_W-1:0] d_c;
   assign d_c = (pos_ff >= ft_ff) ? pos_ff - ft_ff : pos_ff + PERIOD - ft_ff;

   // classify position against the segment
   logic in_seg, before_seg;
   assign in_seg     = (d_ff <= span_ff);
   assign before_seg = ({d_ff, 1'b0} > ({1'b0, PERIOD} + {1'b0, span_ff}));

   // restoring divider, one quotient bit per step
   logic             div_ge;
   logic [ANGLE_W:0] div_rem;
   assign div_ge  = (rem_ff >= {1'b0, span_ff});
   assign div_rem = div_ge ? rem_ff - {1'b0, span_ff} : rem_ff;

   // lerp: a + round((b - a) * f / 65536)
   logic [CHAN_W-1:0]      chan_a, chan_b;
   logic signed [CHAN_W:0] chan_diff;
   logic signed [CHAN_W+FRAC_W+1:0] lerp_prod, lerp_sum;
   logic [CHAN_W+2:0]      lerp_out;
   logic [KEY_W-1:0]       key_a, key_b;
   assign key_a     = keys[cur_from_ff[KI_W-1:0]];
   assign key_b     = keys[cur_to_ff[KI_W-1:0]];
   assign chan_a    = key_a[cmd.mix_chan*CHAN_W +: CHAN_W];
   assign chan_b    = key_b[cmd.mix_chan*CHAN_W +: CHAN_W];
   assign chan_diff = $signed({1'b0, chan_b}) - $signed({1'b0, chan_a});
   assign lerp_prod = chan_diff * $signed({1'b0, quo_ff});
   assign lerp_sum  = lerp_prod + (CHAN_W+FRAC_W+2)'(32768);
   assign lerp_out  = (CHAN_W+3)'(chan_a) + lerp_sum[CHAN_W+FRAC_W+1:16];

   // key step
   logic [IDX_W-1:0] used_cnt, next_to;
   assign used_cnt = (key_count < MIN_KEYS) ? MIN_KEYS :
                     (key_count > KEYS_LIM) ? KEYS_LIM : key_count;
   assign next_to  = ((cur_to_ff + 3'd1) >= used_cnt) ? '0 : cur_to_ff + 3'd1;

   always_comb begin
      status.div_needed = in_seg && (span_ff != '0);
      status.slot_free  = !rsp_valid_ff || rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         elapsed_ff <= req_elapsed_time;
      end
      if (cmd.mul) begin
         delta_ff <= adv_prod[ELAPSED_W+RATE_W-1:16];
      end
      if (cmd.pos) begin
         cur_from_ff <= safe_from;
         cur_to_ff   <= safe_to;
         ft_ff       <= ft_c;
         span_ff     <= span_c;
      end
      if (cmd.offset) begin
         d_ff <= d_c;
      end
      if (cmd.setup) begin
         rem_ff  <= {1'b0, d_ff};
         step_ff <= !in_seg && !before_seg;
         if (in_seg) begin
            quo_ff <= (span_ff == '0) ? ONE_Q16 : '0;
         end else begin
            quo_ff <= before_seg ? '0 : ONE_Q16;
         end
      end
      if (cmd.div_step) begin
         rem_ff <= {div_rem[ANGLE_W-1:0], 1'b0};
         quo_ff <= {quo_ff[FRAC_W-2:0], div_ge};
      end
      if (cmd.mix_step) begin
         col_ff[cmd.mix_chan] <= lerp_out[CHAN_W-1:0];
      end
      if (cmd.out_load) begin
         red_ff   <= col_ff[0];
         green_ff <= col_ff[1];
         blue_ff  <= col_ff[2];
         seg_ff   <= cur_from_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= POS_RESET;
         from_ff      <= 3'd0;
         to_ff        <= 3'd1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.pos) begin
            pos_ff <= pos_in;
         end
         if (cmd.out_load) begin
            from_ff      <= step_ff ? cur_to_ff : cur_from_ff;
            to_ff        <= step_ff ? next_to : cur_to_ff;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_red_out      = red_ff;
   assign rsp_green_out    = green_ff;
   assign rsp_blue_out     = blue_ff;
   assign rsp_segment_from = seg_ff;

endmodule

>>> sv/keyframe_color_ramp.sv
// keyframe color ramp: one item at a time, a new item is taken only once the last is in the output register
// the segment fraction comes from a 17-step restoring divider, followed by 3 lerp steps
// a finished result waits in the output register while the next item is taken
// reset (synchronous): configuration registers to defaults, position one unit before key 0, segment 0 to 1
module keyframe_color_ramp #(
   parameter int MAX_KEYS = kcr_pkg::KEYS_MAX
) (
   input  logic                            clock,
   input  logic                            reset,
   // item input
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [kcr_pkg::ELAPSED_W-1:0]   req_elapsed_time,
   // result output
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [kcr_pkg::CHAN_W-1:0]      rsp_red_out,
   output logic [kcr_pkg::CHAN_W-1:0]      rsp_green_out,
   output logic [kcr_pkg::CHAN_W-1:0]      rsp_blue_out,
   output logic [kcr_pkg::IDX_W-1:0]       rsp_segment_from,
   // configuration writes
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [kcr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [kcr_pkg::KEY_W-1:0]       csr_data
);
   import kcr_pkg::*;

   // register file outputs
   logic [RATE_W-1:0]  advance_rate;
   logic [COUNT_W-1:0] key_count;
   logic [KEY_W-1:0]   keys [MAX_KEYS];

   // controller to datapath
   cmd_type    cmd;
   status_type status;

   // every transfer on the csr channel is accepted at once, the port never stalls
   kcr_csr #(
      .MAX_KEYS(MAX_KEYS)
   ) u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .csr_ready    (csr_ready),
      .advance_rate (advance_rate),
      .key_count    (key_count),
      .keys         (keys)
   );

   // sequencer: accept, advance multiply, position wrap, distance, classify,
   // divide (only inside the segment with a nonzero span), three lerps, output
   kcr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath holds the cycle position and the keyframe indices as well
   kcr_dp #(
      .MAX_KEYS(MAX_KEYS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_elapsed_time (req_elapsed_time),
      .advance_rate     (advance_rate),
      .key_count        (key_count),
      .keys             (keys),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_red_out      (rsp_red_out),
      .rsp_green_out    (rsp_green_out),
      .rsp_blue_out     (rsp_blue_out),
      .rsp_segment_from (rsp_segment_from)
   );

endmodule
